// ===== rtl/shca_pkg.sv =====
// Shared types and constants for the sampled hit-count alarm.
// No dependencies; shca_core and the top level import this package.
`timescale 1ns / 1ps

package shca_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_SCAN_PERIOD   = 2'd0;
  localparam logic [1:0] CFG_REQUIRED_HITS = 2'd1;
  localparam logic [1:0] CFG_ALARM_HOLD    = 2'd2;

  // Register reset values
  localparam logic [15:0] SCAN_PERIOD_RESET   = 16'd50;
  localparam logic [7:0]  REQUIRED_HITS_RESET = 8'd5;
  localparam logic [15:0] ALARM_HOLD_RESET    = 16'd1000;

  // Extra ticks added to the hit window
  localparam logic [24:0] WINDOW_EXTRA = 25'd500;
  localparam logic [24:0] WINDOW_LIMIT_RESET = 25'd750;

  // Saturation limits of the counters
  localparam logic [15:0] MAX16 = 16'hFFFF;
  localparam logic [24:0] MAX25 = 25'h1FF_FFFF;
  localparam logic [7:0]  MAX8  = 8'hFF;

  // Configuration seen by the tick update logic
  typedef struct packed {
    logic [15:0] scan_period;
    logic [7:0]  required_hits;
    logic [15:0] alarm_hold;
    logic [24:0] window_limit;
  } cfg_t;

  // Result of one tick
  typedef struct packed {
    logic alarm_active;
    logic alarm_triggered;
  } result_t;

endpackage

// ===== rtl/shca_if.sv =====
// Handshake interfaces for the sampled hit-count alarm: pin ticks,
// alarm results and configuration writes. Depends on nothing.
`timescale 1ns / 1ps

interface shca_pin_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

interface shca_alarm_if;
  logic valid;
  logic ready;
  logic alarm_active;
  logic alarm_triggered;

  modport source (output valid, output alarm_active, output alarm_triggered, input ready);
  modport sink (input valid, input alarm_active, input alarm_triggered, output ready);
endinterface

interface shca_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/shca_core.sv =====
// Tick update of the sampled hit-count alarm: elapsed counters, hit count
// and alarm flag. Depends on shca_pkg.
`timescale 1ns / 1ps

module shca_core
  import shca_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  logic    pin_level,
  input  cfg_t    cfg,
  output result_t result
);

  logic [15:0] since_scan, since_scan_next;
  logic [24:0] since_window, since_window_next;
  logic [15:0] since_alarm, since_alarm_next;
  logic [7:0]  hit_count, hit_count_next;
  logic        alarm_flag, alarm_flag_next;

  logic [15:0] scan_inc, alarm_inc;
  logic [24:0] window_inc;
  logic [7:0]  hits_sampled, hits_windowed;
  logic        scan_due, window_due, hold_over, alarm_kept, trig;

  // Work out the next state for one tick
  always_comb begin
    scan_inc   = (since_scan >= MAX16) ? MAX16 : since_scan + 16'd1;
    window_inc = (since_window >= MAX25) ? MAX25 : since_window + 25'd1;
    alarm_inc  = (since_alarm >= MAX16) ? MAX16 : since_alarm + 16'd1;

    scan_due = scan_inc >= cfg.scan_period;
    since_scan_next = scan_due ? 16'd0 : scan_inc;
    if (scan_due && pin_level) begin
      hits_sampled = (hit_count >= MAX8) ? MAX8 : hit_count + 8'd1;
    end else begin
      hits_sampled = hit_count;
    end

    window_due = window_inc >= cfg.window_limit;
    since_window_next = window_due ? 25'd0 : window_inc;
    hits_windowed = window_due ? 8'd0 : hits_sampled;

    hold_over  = alarm_inc >= cfg.alarm_hold;
    alarm_kept = alarm_flag && !hold_over;

    trig = hits_windowed >= cfg.required_hits;
    hit_count_next   = trig ? 8'd0 : hits_windowed;
    alarm_flag_next  = trig || alarm_kept;
    since_alarm_next = trig ? 16'd0 : alarm_inc;
  end

  assign result.alarm_active    = alarm_flag_next;
  assign result.alarm_triggered = trig;

  // Advance the state once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      since_scan   <= 16'd0;
      since_window <= 25'd0;
      since_alarm  <= 16'd0;
      hit_count    <= 8'd0;
      alarm_flag   <= 1'b0;
    end else if (advance) begin
      since_scan   <= since_scan_next;
      since_window <= since_window_next;
      since_alarm  <= since_alarm_next;
      hit_count    <= hit_count_next;
      alarm_flag   <= alarm_flag_next;
    end
  end

  // A trigger leaves the alarm raised with a fresh hold timer
  a_trig_restarts_hold: assert property (@(posedge clk) disable iff (rst)
    advance && trig |=> alarm_flag && since_alarm == 16'd0)
    else $error("trigger did not raise alarm and restart hold");

  // Without a trigger the count stays below the threshold
  a_count_below_threshold: assert property (@(posedge clk) disable iff (rst)
    advance && !trig |=> hit_count < $past(cfg.required_hits))
    else $error("hit count reached threshold without trigger");

  // Hold the state while no tick moves
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(since_scan) && $stable(hit_count) && $stable(alarm_flag))
    else $error("state changed without a tick");

endmodule

// ===== rtl/sampled_hit_count_alarm_unit.sv =====
// Top level of the sampled hit-count alarm: input register, config
// registers, tick update core and result register.
// Depends on shca_pkg, shca_if.sv and shca_core.
//
//   channel  modport  payload                          role
//   pin      sink     pin_level                        one tick per transaction
//   alarm    source   alarm_active, alarm_triggered    one result per tick
//   cfg      sink     reg_index[1:0], wdata[15:0]      register write, always ready
//
// From acceptance to result a tick passes the input register, then the state
// update into the result register. One tick is accepted every cycle while
// results are taken. Reset (rst, synchronous) clears the state and loads
// register defaults. A stalled result holds the result register; the input
// register still takes one more tick, then pin.ready drops until the result
// is taken. The window limit is registered from the config registers; after
// a write it follows once the config and window limit registers have loaded.
`timescale 1ns / 1ps

module sampled_hit_count_alarm_unit
  import shca_pkg::*;
(
  input  logic clk,
  input  logic rst,
  shca_pin_if.sink     pin,
  shca_alarm_if.source alarm,
  shca_cfg_if.sink     cfg
);

  cfg_t        cfg_q;
  logic [23:0] hit_span;
  logic [24:0] window_limit_next;

  logic        in_valid;
  logic        in_pin;
  logic        advance;
  result_t     result;

  logic        out_valid;
  result_t     out_result;

  // Accept config writes at any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.scan_period   <= SCAN_PERIOD_RESET;
      cfg_q.required_hits <= REQUIRED_HITS_RESET;
      cfg_q.alarm_hold    <= ALARM_HOLD_RESET;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        CFG_SCAN_PERIOD:   cfg_q.scan_period   <= cfg.wdata;
        CFG_REQUIRED_HITS: cfg_q.required_hits <= cfg.wdata[7:0];
        CFG_ALARM_HOLD:    cfg_q.alarm_hold    <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Register the window limit: hits times period plus the extra ticks
  assign hit_span          = {16'd0, cfg_q.required_hits} * {8'd0, cfg_q.scan_period};
  assign window_limit_next = {1'b0, hit_span} + WINDOW_EXTRA;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.window_limit <= WINDOW_LIMIT_RESET;
    end else begin
      cfg_q.window_limit <= window_limit_next;
    end
  end

  // Move a tick on when the result register is free or being emptied
  assign advance   = in_valid && (!out_valid || alarm.ready);
  assign pin.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pin.ready) begin
      in_valid <= pin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pin.ready && pin.valid) begin
      in_pin <= pin.pin_level;
    end
  end

  shca_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .pin_level (in_pin),
    .cfg       (cfg_q),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (alarm.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign alarm.valid           = out_valid;
  assign alarm.alarm_active    = out_result.alarm_active;
  assign alarm.alarm_triggered = out_result.alarm_triggered;

  // A trigger always comes with an active alarm
  a_trig_implies_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.alarm_triggered |-> out_result.alarm_active)
    else $error("triggered result without active alarm");

  // Input stalls only while a tick waits in the input register
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !pin.ready |-> in_valid && out_valid && !alarm.ready)
    else $error("input stalled with room to move");

  // Window limit matches the config registers except right after a write or a reset
  a_window_limit_current: assert property (@(posedge clk) disable iff (rst)
    !$past(cfg.valid) && !$past(rst) |-> cfg_q.window_limit == window_limit_next)
    else $error("window limit out of date");

endmodule
